// ----- hdl/ddhb_pkg.sv -----
// ----------------------------------------------------------------------------
// ddhb_pkg: shared definitions for the differential-drive H-bridge command block
// Command codes, register indexes, fixed-point constants and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ddhb_pkg;

   // Command codes carried in the request.
   localparam logic [3:0] CMD_COAST      = 4'd0;
   localparam logic [3:0] CMD_BRAKE      = 4'd1;
   localparam logic [3:0] CMD_WHEEL      = 4'd2;
   localparam logic [3:0] CMD_FORWARD    = 4'd3;
   localparam logic [3:0] CMD_BACKWARD   = 4'd4;
   localparam logic [3:0] CMD_TURN_LEFT  = 4'd5;
   localparam logic [3:0] CMD_TURN_RIGHT = 4'd6;
   localparam logic [3:0] CMD_SPIN_LEFT  = 4'd7;
   localparam logic [3:0] CMD_SPIN_RIGHT = 4'd8;
   localparam logic [3:0] CMD_HEADING    = 4'd9;

   // Register indexes (word address bits).
   localparam logic [1:0] REG_HEADING_GAIN = 2'd0;
   localparam logic [1:0] REG_LEFT_MIN     = 2'd1;
   localparam logic [1:0] REG_RIGHT_MIN    = 2'd2;

   localparam int CSR_ADDR_WIDTH = 4;

   // Register reset values.
   localparam logic [15:0] GAIN_RESET     = 16'd256;
   localparam logic [6:0]  MIN_SPEED_RESET = 7'd3;

   // Percent limit.
   localparam logic [6:0] PCT_MAX = 7'd100;

   // Shared multiplier operand widths. A percent times the largest period
   // stays below 2**23, and floor(x / 100) == (x * RECIP_100) >> 30 is exact
   // over that whole range.
   localparam int MUL_A_WIDTH = 24;
   localparam int MUL_B_WIDTH = 23;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam logic [MUL_A_WIDTH-1:0] RECIP_100 = 24'd10737419;
   localparam int RECIP_SHIFT = 30;

   // Yaw is in 1/128 degree.
   localparam logic signed [16:0] HALF_TURN = 17'sd23040;
   localparam logic signed [16:0] FULL_TURN = 17'sd46080;

   // Duty fields are 10 bits wide.
   localparam int DUTY_WIDTH = 10;

endpackage

`default_nettype wire

// ----- hdl/ddhb_if.sv -----
// ----------------------------------------------------------------------------
// ddhb_if: request and result channels of the H-bridge command block
// Valid/ready channels carrying a drive command and the four compare values.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddhb_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         command;
   logic [7:0]         base_speed;
   logic [7:0]         turn_ratio;
   logic signed [10:0] left_signed_speed;
   logic signed [10:0] right_signed_speed;
   logic signed [15:0] heading;
   logic               heading_valid;

   modport source (
      output valid, command, base_speed, turn_ratio, left_signed_speed,
             right_signed_speed, heading, heading_valid,
      input  ready
   );
   modport sink (
      input  valid, command, base_speed, turn_ratio, left_signed_speed,
             right_signed_speed, heading, heading_valid,
      output ready
   );
endinterface

interface ddhb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] right_in1_duty;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] right_in2_duty;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] left_in1_duty;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] left_in2_duty;

   modport source (
      output valid, right_in1_duty, right_in2_duty, left_in1_duty, left_in2_duty,
      input  ready
   );
   modport sink (
      input  valid, right_in1_duty, right_in2_duty, left_in1_duty, left_in2_duty,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/diff_drive_hbridge_pwm_command.sv -----
// ----------------------------------------------------------------------------
// diff_drive_hbridge_pwm_command: drive command to H-bridge compare values
// Turns one drive request into IN1/IN2 compare values for both wheels.
// ----------------------------------------------------------------------------
// A request is taken when the block is idle and runs through a nine-step
// sequencer around one shared 24 x 23 bit multiplier (turn scaling, heading
// correction, then percent-to-duty for each wheel; the turn scaling and each
// percent-to-duty step are followed by an exact reciprocal divide by 100), so
// a request that produces a result reaches the result register before the
// block returns to idle and can take the next request. The result register
// lets the block finish its last step only once the previous result has been
// taken. Unknown commands and heading hold with an invalid yaw are absorbed in
// the accept cycle with no result. Heading hold latches the first valid yaw as
// its reference; the gain and wheel floors are APB registers at byte offsets
// 0, 4 and 8.
`default_nettype none

module diff_drive_hbridge_pwm_command #(
   parameter int PERIOD_COUNTS = 1000
) (
   input  wire                                   clock,
   input  wire                                   reset,
   ddhb_req_if.sink                              req_bus,
   ddhb_rsp_if.source                            rsp_bus,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [ddhb_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire  [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam logic [15:0] PERIOD_VAL = 16'(PERIOD_COUNTS);

   typedef enum logic [9:0] {
      ST_IDLE        = 10'b0000000001,
      ST_ERROR       = 10'b0000000010,
      ST_INNER_DIV   = 10'b0000000100,
      ST_HEAD_MUL    = 10'b0000001000,
      ST_SELECT      = 10'b0000010000,
      ST_LEFT_SCALE  = 10'b0000100000,
      ST_LEFT_DIV    = 10'b0001000000,
      ST_RIGHT_SCALE = 10'b0010000000,
      ST_RIGHT_DIV   = 10'b0100000000,
      ST_OUTPUT      = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] gain_ff, gain_in;
   logic [6:0]  left_min_ff, left_min_in;
   logic [6:0]  right_min_ff, right_min_in;

   // Heading reference.
   logic [15:0] ref_heading_ff, ref_heading_in;
   logic        ref_latched_ff, ref_latched_in;

   // Captured request.
   logic [3:0]         cmd_ff, cmd_in;
   logic [6:0]         speed_ff, speed_in;
   logic [6:0]         ratio_ff, ratio_in;
   logic signed [10:0] left_ss_ff, left_ss_in;
   logic signed [10:0] right_ss_ff, right_ss_in;
   logic signed [15:0] yaw_ff, yaw_in;

   // Working registers.
   logic [14:0] err_mag_ff, err_mag_in;
   logic        err_neg_ff, err_neg_in;
   logic [6:0]  inner_ff, inner_in;
   logic [6:0]  left_pct_ff, left_pct_in;
   logic [6:0]  right_pct_ff, right_pct_in;
   logic        left_fwd_ff, left_fwd_in;
   logic        right_fwd_ff, right_fwd_in;
   logic        brake_ff, brake_in;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] left_duty_ff, left_duty_in;
   logic [ddhb_pkg::PROD_WIDTH-1:0] prod_ff, prod_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] r_in1_ff, r_in1_in;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] r_in2_ff, r_in2_in;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] l_in1_ff, l_in1_in;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] l_in2_ff, l_in2_in;

   // Shared multiplier.
   logic [ddhb_pkg::MUL_A_WIDTH-1:0] mul_a;
   logic [ddhb_pkg::MUL_B_WIDTH-1:0] mul_b;

   logic        accept;
   logic        cmd_known;
   logic        csr_write;
   logic        finish;

   // Heading error and wheel selection terms.
   logic signed [16:0] err_raw;
   logic signed [16:0] err_wrap;
   logic [15:0]        corr_mag;
   logic signed [17:0] speed_ext;
   logic signed [17:0] corr_ext;
   logic signed [17:0] left_raw;
   logic signed [17:0] right_raw;
   logic signed [17:0] left_floor;
   logic signed [17:0] right_floor;
   logic signed [17:0] left_lim;
   logic signed [17:0] right_lim;
   logic [6:0]         left_hold;
   logic [6:0]         right_hold;
   logic [11:0]        left_ss_ext;
   logic [11:0]        right_ss_ext;
   logic [11:0]        left_ss_mag;
   logic [11:0]        right_ss_mag;
   logic [6:0]         left_ss_pct;
   logic [6:0]         right_ss_pct;
   logic [ddhb_pkg::DUTY_WIDTH-1:0] right_duty;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign cmd_known     = (req_bus.command <= ddhb_pkg::CMD_HEADING);
   assign finish        = (state_ff == ST_OUTPUT) & (~rsp_valid_ff | rsp_bus.ready);

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.right_in1_duty = r_in1_ff;
   assign rsp_bus.right_in2_duty = r_in2_ff;
   assign rsp_bus.left_in1_duty  = l_in1_ff;
   assign rsp_bus.left_in2_duty  = l_in2_ff;

   // Register read-back.
   always_comb begin
      case (paddr[3:2])
         ddhb_pkg::REG_HEADING_GAIN: prdata = {16'd0, gain_ff};
         ddhb_pkg::REG_LEFT_MIN:     prdata = {25'd0, left_min_ff};
         ddhb_pkg::REG_RIGHT_MIN:    prdata = {25'd0, right_min_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   // Heading error, wrapped once into plus or minus half a turn.
   always_comb begin
      err_raw = {yaw_ff[15], yaw_ff} - {ref_heading_ff[15], ref_heading_ff};
      if (err_raw > ddhb_pkg::HALF_TURN) begin
         err_wrap = err_raw - ddhb_pkg::FULL_TURN;
      end else if (err_raw < -ddhb_pkg::HALF_TURN) begin
         err_wrap = err_raw + ddhb_pkg::FULL_TURN;
      end else begin
         err_wrap = err_raw;
      end
   end

   // Heading-hold wheel percents from the registered correction magnitude.
   always_comb begin
      corr_mag    = prod_ff[30:15];
      speed_ext   = {11'd0, speed_ff};
      corr_ext    = {2'd0, corr_mag};
      left_raw    = err_neg_ff ? (speed_ext + corr_ext) : (speed_ext - corr_ext);
      right_raw   = err_neg_ff ? (speed_ext - corr_ext) : (speed_ext + corr_ext);
      left_floor  = {11'd0, left_min_ff};
      right_floor = {11'd0, right_min_ff};
      left_lim    = (left_raw < left_floor) ? left_floor : left_raw;
      right_lim   = (right_raw < right_floor) ? right_floor : right_raw;
      left_hold   = (left_lim > 18'sd100) ? ddhb_pkg::PCT_MAX : left_lim[6:0];
      right_hold  = (right_lim > 18'sd100) ? ddhb_pkg::PCT_MAX : right_lim[6:0];
   end

   // Per-wheel signed speeds: magnitude clamped to 100.
   always_comb begin
      left_ss_ext  = {left_ss_ff[10], left_ss_ff};
      right_ss_ext = {right_ss_ff[10], right_ss_ff};
      left_ss_mag  = left_ss_ff[10] ? (~left_ss_ext + 12'd1) : left_ss_ext;
      right_ss_mag = right_ss_ff[10] ? (~right_ss_ext + 12'd1) : right_ss_ext;
      left_ss_pct  = (left_ss_mag > 12'd100) ? ddhb_pkg::PCT_MAX : left_ss_mag[6:0];
      right_ss_pct = (right_ss_mag > 12'd100) ? ddhb_pkg::PCT_MAX : right_ss_mag[6:0];
   end

   assign right_duty = prod_ff[ddhb_pkg::RECIP_SHIFT +: ddhb_pkg::DUTY_WIDTH];

   always_comb begin
      state_in       = state_ff;
      gain_in        = gain_ff;
      left_min_in    = left_min_ff;
      right_min_in   = right_min_ff;
      ref_heading_in = ref_heading_ff;
      ref_latched_in = ref_latched_ff;
      cmd_in         = cmd_ff;
      speed_in       = speed_ff;
      ratio_in       = ratio_ff;
      left_ss_in     = left_ss_ff;
      right_ss_in    = right_ss_ff;
      yaw_in         = yaw_ff;
      err_mag_in     = err_mag_ff;
      err_neg_in     = err_neg_ff;
      inner_in       = inner_ff;
      left_pct_in    = left_pct_ff;
      right_pct_in   = right_pct_ff;
      left_fwd_in    = left_fwd_ff;
      right_fwd_in   = right_fwd_ff;
      brake_in       = brake_ff;
      left_duty_in   = left_duty_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_bus.ready;
      r_in1_in       = r_in1_ff;
      r_in2_in       = r_in2_ff;
      l_in1_in       = l_in1_ff;
      l_in2_in       = l_in2_ff;
      mul_a          = '0;
      mul_b          = '0;

      if (csr_write) begin
         case (paddr[3:2])
            ddhb_pkg::REG_HEADING_GAIN: gain_in      = pwdata[15:0];
            ddhb_pkg::REG_LEFT_MIN:     left_min_in  = pwdata[6:0];
            ddhb_pkg::REG_RIGHT_MIN:    right_min_in = pwdata[6:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_in      = req_bus.command;
            speed_in    = (req_bus.base_speed > 8'd100) ? ddhb_pkg::PCT_MAX
                                                        : req_bus.base_speed[6:0];
            ratio_in    = (req_bus.turn_ratio > 8'd100) ? ddhb_pkg::PCT_MAX
                                                        : req_bus.turn_ratio[6:0];
            left_ss_in  = req_bus.left_signed_speed;
            right_ss_in = req_bus.right_signed_speed;
            yaw_in      = req_bus.heading;
            // Requests that produce no result are absorbed here.
            if (accept && cmd_known &&
                (req_bus.command != ddhb_pkg::CMD_HEADING || req_bus.heading_valid)) begin
               state_in = ST_ERROR;
               if (req_bus.command == ddhb_pkg::CMD_HEADING && !ref_latched_ff) begin
                  ref_heading_in = req_bus.heading;
                  ref_latched_in = 1'b1;
               end
            end
         end
         ST_ERROR: begin
            err_neg_in = err_wrap[16];
            err_mag_in = err_wrap[16] ? 15'(-err_wrap) : err_wrap[14:0];
            mul_a      = {17'd0, speed_ff};
            mul_b      = {16'd0, ratio_ff};
            state_in   = ST_INNER_DIV;
         end
         ST_INNER_DIV: begin
            mul_a    = ddhb_pkg::RECIP_100;
            mul_b    = {9'd0, prod_ff[13:0]};
            state_in = ST_HEAD_MUL;
         end
         ST_HEAD_MUL: begin
            inner_in = speed_ff - prod_ff[ddhb_pkg::RECIP_SHIFT +: 7];
            mul_a    = {8'd0, gain_ff};
            mul_b    = {8'd0, err_mag_ff};
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            left_pct_in  = speed_ff;
            right_pct_in = speed_ff;
            left_fwd_in  = 1'b1;
            right_fwd_in = 1'b1;
            brake_in     = 1'b0;
            case (cmd_ff)
               ddhb_pkg::CMD_COAST: begin
                  left_pct_in  = 7'd0;
                  right_pct_in = 7'd0;
               end
               ddhb_pkg::CMD_BRAKE: begin
                  left_pct_in  = ddhb_pkg::PCT_MAX;
                  right_pct_in = ddhb_pkg::PCT_MAX;
                  brake_in     = 1'b1;
               end
               ddhb_pkg::CMD_WHEEL: begin
                  left_pct_in  = left_ss_pct;
                  right_pct_in = right_ss_pct;
                  left_fwd_in  = ~left_ss_ff[10];
                  right_fwd_in = ~right_ss_ff[10];
               end
               ddhb_pkg::CMD_BACKWARD: begin
                  left_fwd_in  = 1'b0;
                  right_fwd_in = 1'b0;
               end
               ddhb_pkg::CMD_TURN_LEFT:  left_pct_in  = inner_ff;
               ddhb_pkg::CMD_TURN_RIGHT: right_pct_in = inner_ff;
               ddhb_pkg::CMD_SPIN_LEFT:  left_fwd_in  = 1'b0;
               ddhb_pkg::CMD_SPIN_RIGHT: right_fwd_in = 1'b0;
               ddhb_pkg::CMD_HEADING: begin
                  left_pct_in  = left_hold;
                  right_pct_in = right_hold;
               end
               default: begin
               end
            endcase
            state_in = ST_LEFT_SCALE;
         end
         ST_LEFT_SCALE: begin
            mul_a    = {17'd0, left_pct_ff};
            mul_b    = {7'd0, PERIOD_VAL};
            state_in = ST_LEFT_DIV;
         end
         ST_LEFT_DIV: begin
            mul_a    = ddhb_pkg::RECIP_100;
            mul_b    = prod_ff[ddhb_pkg::MUL_B_WIDTH-1:0];
            state_in = ST_RIGHT_SCALE;
         end
         ST_RIGHT_SCALE: begin
            left_duty_in = prod_ff[ddhb_pkg::RECIP_SHIFT +: ddhb_pkg::DUTY_WIDTH];
            mul_a        = {17'd0, right_pct_ff};
            mul_b        = {7'd0, PERIOD_VAL};
            state_in     = ST_RIGHT_DIV;
         end
         ST_RIGHT_DIV: begin
            mul_a    = ddhb_pkg::RECIP_100;
            mul_b    = prod_ff[ddhb_pkg::MUL_B_WIDTH-1:0];
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               if (brake_ff) begin
                  r_in1_in = right_duty;
                  r_in2_in = right_duty;
                  l_in1_in = left_duty_ff;
                  l_in2_in = left_duty_ff;
               end else begin
                  r_in1_in = right_fwd_ff ? right_duty : '0;
                  r_in2_in = right_fwd_ff ? '0 : right_duty;
                  l_in1_in = left_fwd_ff ? left_duty_ff : '0;
                  l_in2_in = left_fwd_ff ? '0 : left_duty_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The product register holds its value while the result waits.
   assign prod_in = (state_ff == ST_OUTPUT) ? prod_ff : (mul_a * mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gain_ff        <= ddhb_pkg::GAIN_RESET;
         left_min_ff    <= ddhb_pkg::MIN_SPEED_RESET;
         right_min_ff   <= ddhb_pkg::MIN_SPEED_RESET;
         ref_heading_ff <= '0;
         ref_latched_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gain_ff        <= gain_in;
         left_min_ff    <= left_min_in;
         right_min_ff   <= right_min_in;
         ref_heading_ff <= ref_heading_in;
         ref_latched_ff <= ref_latched_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      speed_ff     <= speed_in;
      ratio_ff     <= ratio_in;
      left_ss_ff   <= left_ss_in;
      right_ss_ff  <= right_ss_in;
      yaw_ff       <= yaw_in;
      err_mag_ff   <= err_mag_in;
      err_neg_ff   <= err_neg_in;
      inner_ff     <= inner_in;
      left_pct_ff  <= left_pct_in;
      right_pct_ff <= right_pct_in;
      left_fwd_ff  <= left_fwd_in;
      right_fwd_ff <= right_fwd_in;
      brake_ff     <= brake_in;
      left_duty_ff <= left_duty_in;
      prod_ff      <= prod_in;
      r_in1_ff     <= r_in1_in;
      r_in2_ff     <= r_in2_in;
      l_in1_ff     <= l_in1_in;
      l_in2_ff     <= l_in2_in;
   end

endmodule

`default_nettype wire
